/* design/kmpd_pkg.sv */
// kmpd_pkg: constants and codes for the keyboard/mouse packet decoder.
// Standalone package; used by keyboard_mouse_packet_decoder_unit.
package kmpd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned ROW_W     = 3;
    localparam int unsigned ROW_BITS  = 16;
    localparam int unsigned POS_W     = 32;
    localparam int unsigned BTN_W     = 2;
    localparam int unsigned PEND_W    = 2;
    localparam int unsigned NUM_ROWS  = 8;

    localparam logic [BYTE_W-1:0] HEADER_MIN = 8'd248;
    localparam logic [POS_W-1:0]  POS_RESET  = 32'd128;

    // Pending delta count: idle, Y next, X next.
    localparam logic [PEND_W-1:0] PEND_IDLE = 2'd0;
    localparam logic [PEND_W-1:0] PEND_Y    = 2'd1;
    localparam logic [PEND_W-1:0] PEND_X    = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_KEY    = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_DX     = 2'd2,
        KIND_DY     = 2'd3
    } byte_kind_t;

    typedef logic [ROW_BITS-1:0] key_row_t;

endpackage

/* design/keyboard_mouse_packet_decoder_unit.sv */
// keyboard_mouse_packet_decoder_unit: decodes key codes and relative mouse packets.
// Depends on kmpd_pkg (codes, widths, reset constants).
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | to block  | in_valid / in_stall  | link_byte
//  out     | from block| out_valid / out_stall| byte_kind key_row key_row_bits mouse_x
//          |           |                      | mouse_y button_bits
//
// Two register stages: an input register, then one pass of decode/update logic into
// the result register. One request per cycle is sustained while out_stall is low.
// The decode state (key map, mouse position, pending count) updates in the same edge
// that loads the result register, so the next byte always sees fresh state.
// Reset clears control state, key map and mouse state (positions to 128).
// out_stall holds the result register; the input register then holds too and
// in_stall rises only when the input register is occupied and cannot move on.
module keyboard_mouse_packet_decoder_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [kmpd_pkg::BYTE_W-1:0] link_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [kmpd_pkg::KIND_W-1:0] byte_kind,
    output logic [kmpd_pkg::ROW_W-1:0]  key_row,
    output logic [kmpd_pkg::ROW_BITS-1:0] key_row_bits,
    output logic [kmpd_pkg::POS_W-1:0]  mouse_x,
    output logic [kmpd_pkg::POS_W-1:0]  mouse_y,
    output logic [kmpd_pkg::BTN_W-1:0]  button_bits
);
    import kmpd_pkg::*;

    // input register
    logic              in_vld_reg;
    logic [BYTE_W-1:0] byte_reg;

    // decode state
    key_row_t          key_map_reg [NUM_ROWS];
    logic [PEND_W-1:0] pending_reg;
    logic [POS_W-1:0]  pos_x_reg;
    logic [POS_W-1:0]  pos_y_reg;
    logic [BTN_W-1:0]  buttons_reg;

    // result register
    logic              out_vld_reg;
    byte_kind_t        kind_reg;
    logic [ROW_W-1:0]  row_reg;
    key_row_t          row_bits_reg;

    // next values
    byte_kind_t        kind_next;
    logic [ROW_W-1:0]  row_next;
    key_row_t          row_bits_next;
    logic [PEND_W-1:0] pending_next;
    logic [POS_W-1:0]  pos_x_next;
    logic [POS_W-1:0]  pos_y_next;
    logic [BTN_W-1:0]  buttons_next;
    logic              key_write;

    logic              out_load;
    logic              in_take;
    logic [ROW_W-1:0]  sel_row;
    key_row_t          bit_mask;
    key_row_t          row_upd;
    logic [POS_W-1:0]  delta;

    // result register frees up when empty or being taken
    assign out_load = !out_vld_reg || !out_stall;
    assign in_stall = in_vld_reg && !out_load;
    assign in_take  = in_valid && !in_stall;

    assign sel_row  = byte_reg[6:4];
    assign bit_mask = key_row_t'(1) << byte_reg[3:0];
    // bit 7 set: break clears the bit, else make sets it
    assign row_upd  = byte_reg[BYTE_W-1] ? (key_map_reg[sel_row] & ~bit_mask)
                                         : (key_map_reg[sel_row] | bit_mask);
    assign delta    = {{(POS_W-BYTE_W){byte_reg[BYTE_W-1]}}, byte_reg};

    always_comb
    begin
        kind_next     = KIND_KEY;
        row_next      = '0;
        row_bits_next = '0;
        pending_next  = pending_reg;
        pos_x_next    = pos_x_reg;
        pos_y_next    = pos_y_reg;
        buttons_next  = buttons_reg;
        key_write     = 1'b0;
        if (pending_reg == PEND_IDLE)
        begin
            if (byte_reg >= HEADER_MIN)
            begin
                kind_next    = KIND_HEADER;
                buttons_next = byte_reg[BTN_W-1:0];
                pending_next = PEND_X;
            end
            else
            begin
                kind_next     = KIND_KEY;
                row_next      = sel_row;
                row_bits_next = row_upd;
                key_write     = 1'b1;
            end
        end
        else
        begin
            // a count of three is taken as an X delta
            if (pending_reg == PEND_Y)
            begin
                kind_next  = KIND_DY;
                pos_y_next = pos_y_reg + delta;
            end
            else
            begin
                kind_next  = KIND_DX;
                pos_x_next = pos_x_reg + delta;
            end
            pending_next = pending_reg - PEND_Y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            pending_reg <= PEND_IDLE;
            pos_x_reg   <= POS_RESET;
            pos_y_reg   <= POS_RESET;
            buttons_reg <= '0;
            for (int i = 0; i < NUM_ROWS; i++)
            begin
                key_map_reg[i] <= '0;
            end
        end
        else
        begin
            // input register fills on a taken request, empties when it moves on
            if (in_take)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (out_load)
            begin
                in_vld_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_vld_reg <= in_vld_reg;
            end
            if (out_load && in_vld_reg)
            begin
                pending_reg <= pending_next;
                pos_x_reg   <= pos_x_next;
                pos_y_reg   <= pos_y_next;
                buttons_reg <= buttons_next;
                if (key_write)
                begin
                    key_map_reg[sel_row] <= row_upd;
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= link_byte;
        end
        if (out_load && in_vld_reg)
        begin
            kind_reg     <= kind_next;
            row_reg      <= row_next;
            row_bits_reg <= row_bits_next;
        end
    end

    assign out_valid    = out_vld_reg;
    assign byte_kind    = kind_reg;
    assign key_row      = row_reg;
    assign key_row_bits = row_bits_reg;
    assign mouse_x      = pos_x_reg;
    assign mouse_y      = pos_y_reg;
    assign button_bits  = buttons_reg;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for keyboard_mouse_packet_decoder_unit.
// Depends on kmpd_pkg and the decoder RTL; carries its own decode model.
module testbench;
    import kmpd_pkg::*;

    localparam int CLK_HALF     = 2;        // 4 ns period
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 1650;
    localparam int MAX_GAP      = 17;
    localparam int HOLD_OFF     = 150;      // long receiver stall, in cycles
    localparam int SQUEEZE_LEN  = 40;       // back-to-back requests during it
    localparam int DRAIN_CYCLES = 8;        // margin after the queue drains
    localparam int CYCLE_LIMIT  = 400000;

    // One decoded result, in port order.
    typedef struct packed {
        byte_kind_t           kind;
        logic [ROW_W-1:0]     row;
        key_row_t             row_bits;
        logic [POS_W-1:0]     pos_x;
        logic [POS_W-1:0]     pos_y;
        logic [BTN_W-1:0]     buttons;
    } decoded_byte_t;

    // Directed stimulus row. When known is set, the result is typed in here;
    // otherwise it comes from the decode model.
    typedef struct packed {
        logic [BYTE_W-1:0] link;
        logic              known;
        decoded_byte_t     result;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 23;
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        // key make at both ends of the code space
        '{8'h00, 1'b1, '{KIND_KEY,    3'd0, 16'h0001, 32'd128, 32'd128, 2'd0}},
        '{8'h7F, 1'b1, '{KIND_KEY,    3'd7, 16'h8000, 32'd128, 32'd128, 2'd0}},
        // header with both buttons, then max positive X and max negative Y
        '{8'hFF, 1'b1, '{KIND_HEADER, 3'd0, 16'h0000, 32'd128, 32'd128, 2'd3}},
        '{8'h7F, 1'b1, '{KIND_DX,     3'd0, 16'h0000, 32'd255, 32'd128, 2'd3}},
        '{8'h80, 1'b1, '{KIND_DY,     3'd0, 16'h0000, 32'd255, 32'd0,   2'd3}},
        // lowest header; deltas of 248 and up are plain deltas; Y wraps below 0
        '{8'hF8, 1'b1, '{KIND_HEADER, 3'd0, 16'h0000, 32'd255, 32'd0,   2'd0}},
        '{8'hFF, 1'b1, '{KIND_DX,     3'd0, 16'h0000, 32'd254, 32'd0,   2'd0}},
        '{8'hF8, 1'b1, '{KIND_DY,     3'd0, 16'h0000, 32'd254, 32'hFFFF_FFF8, 2'd0}},
        // highest key code: break of a key that is not down
        '{8'hF7, 1'b1, '{KIND_KEY,    3'd7, 16'h8000, 32'd254, 32'hFFFF_FFF8, 2'd0}},
        // break of a key that is down, then of one that is not
        '{8'h80, 1'b1, '{KIND_KEY,    3'd0, 16'h0000, 32'd254, 32'hFFFF_FFF8, 2'd0}},
        '{8'h8F, 1'b1, '{KIND_KEY,    3'd0, 16'h0000, 32'd254, 32'hFFFF_FFF8, 2'd0}},
        // remaining rows go through the model
        '{8'h5A, 1'b0, '0},     // make mid row
        '{8'hDA, 1'b0, '0},     // and its break
        '{8'hFA, 1'b0, '0},     // header, button 1
        '{8'h08, 1'b0, '0},
        '{8'h10, 1'b0, '0},     // Y wraps back above 0
        '{8'hF9, 1'b0, '0},     // header, button 0
        '{8'hFC, 1'b0, '0},
        '{8'hFE, 1'b0, '0},
        '{8'h7F, 1'b0, '0},     // make of a key already down
        '{8'hFF, 1'b0, '0},
        '{8'h00, 1'b0, '0},     // zero X delta
        '{8'hFF, 1'b0, '0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [BYTE_W-1:0]     link_byte;
    logic                  out_valid;
    logic                  out_stall;
    logic [KIND_W-1:0]     byte_kind;
    logic [ROW_W-1:0]      key_row;
    logic [ROW_BITS-1:0]   key_row_bits;
    logic [POS_W-1:0]      mouse_x;
    logic [POS_W-1:0]      mouse_y;
    logic [BTN_W-1:0]      button_bits;

    // Decode model state
    key_row_t              model_keys [NUM_ROWS];
    logic [PEND_W-1:0]     model_pending;
    logic [POS_W-1:0]      model_x;
    logic [POS_W-1:0]      model_y;
    logic [BTN_W-1:0]      model_buttons;

    decoded_byte_t         decoded_queue [$];
    int                    mismatch_count;
    int                    cycle_count;
    logic                  squeeze_active;
    logic                  hold_off_done;

    keyboard_mouse_packet_decoder_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .link_byte    (link_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .byte_kind    (byte_kind),
        .key_row      (key_row),
        .key_row_bits (key_row_bits),
        .mouse_x      (mouse_x),
        .mouse_y      (mouse_y),
        .button_bits  (button_bits)
    );

    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    function automatic void reset_model();
        for (int i = 0; i < NUM_ROWS; i++)
            model_keys[i] = '0;
        model_pending = PEND_IDLE;
        model_x       = POS_RESET;
        model_y       = POS_RESET;
        model_buttons = '0;
    endfunction

    // Advances the model by one byte and returns the result it produces.
    function automatic decoded_byte_t decode_link_byte(input logic [BYTE_W-1:0] b);
        decoded_byte_t    r;
        logic [ROW_W-1:0] row;
        logic [POS_W-1:0] delta;
        r     = '0;
        row   = b[6:4];
        delta = {{(POS_W-BYTE_W){b[BYTE_W-1]}}, b};     // sign-extended
        if (model_pending == PEND_IDLE) begin
            if (b >= HEADER_MIN) begin
                model_buttons = b[BTN_W-1:0];
                model_pending = PEND_X;
                r.kind        = KIND_HEADER;
            end
            else begin
                // bit 7 set means release
                if (b[7])
                    model_keys[row][b[3:0]] = 1'b0;
                else
                    model_keys[row][b[3:0]] = 1'b1;
                r.kind     = KIND_KEY;
                r.row      = row;
                r.row_bits = model_keys[row];
            end
        end
        else begin
            // any byte value is a delta here, including header values
            if (model_pending == PEND_Y) begin
                model_y = model_y + delta;
                r.kind  = KIND_DY;
            end
            else begin
                model_x = model_x + delta;
                r.kind  = KIND_DX;
            end
            model_pending = model_pending - 1'b1;
        end
        r.pos_x   = model_x;
        r.pos_y   = model_y;
        r.buttons = model_buttons;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [POS_W-1:0] exp_v,
                                        input logic [POS_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    // Offers one request and waits for it to be taken. The expectation is queued
    // at the accepting edge; typed-in rows still step the model to keep it in sync.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic known,
                             input decoded_byte_t typed, input int gap);
        decoded_byte_t r;
        @(negedge clk);
        in_valid  <= 1'b1;
        link_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        r = decode_link_byte(b);
        decoded_queue.push_back(known ? typed : r);
        // Idle gap: valid drops on the next falling edge, payload goes random.
        if (gap > 0) begin
            @(negedge clk);
            in_valid  <= 1'b0;
            link_byte <= BYTE_W'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        while (decoded_queue.size() != 0)
            @(posedge clk);
    endtask

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Result side: random stall gaps, bursts of no stall, and one long hold-off
    // while the sender pushes back-to-back requests.
    initial begin
        decoded_byte_t exp_r;
        int            gap;
        int            result_index;
        logic          burst;
        out_stall     = 1'b0;
        hold_off_done = 1'b0;
        result_index  = 0;
        burst         = 1'b0;
        @(posedge rst_n);
        forever begin
            if (result_index % 100 == 0)
                burst = ($urandom_range(0, 2) == 0);
            gap = burst ? 0 : $urandom_range(0, MAX_GAP);
            if (squeeze_active && !hold_off_done) begin
                gap           = HOLD_OFF;
                hold_off_done = 1'b1;
            end
            if (gap > 0) begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            result_index++;
            if (decoded_queue.size() == 0) begin
                $error("result with no request outstanding: kind %0d", byte_kind);
                mismatch_count++;
            end
            else begin
                exp_r = decoded_queue.pop_front();
                check_field("byte_kind",    POS_W'(exp_r.kind),     POS_W'(byte_kind));
                check_field("key_row",      POS_W'(exp_r.row),      POS_W'(key_row));
                check_field("key_row_bits", POS_W'(exp_r.row_bits), POS_W'(key_row_bits));
                check_field("mouse_x",      exp_r.pos_x,            mouse_x);
                check_field("mouse_y",      exp_r.pos_y,            mouse_y);
                check_field("button_bits",  POS_W'(exp_r.buttons),  POS_W'(button_bits));
            end
        end
    end

    // Request side: reset, directed table, then random traffic.
    initial begin
        int   sent;
        int   pick;
        int   squeeze_at;
        logic burst;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        link_byte      = '0;
        mismatch_count = 0;
        squeeze_active = 1'b0;
        burst          = 1'b0;
        reset_model();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_byte(DIRECTED[i].link, DIRECTED[i].known, DIRECTED[i].result,
                      $urandom_range(0, MAX_GAP));

        // Sender pauses until every outstanding result is back.
        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained();

        sent       = 0;
        squeeze_at = $urandom_range(RANDOM_ITEMS / 4, RANDOM_ITEMS / 2);
        while (sent < RANDOM_ITEMS) begin
            if (sent % 100 == 0)
                burst = ($urandom_range(0, 2) == 0);
            // Long receiver hold-off: keep offering with no gaps so the
            // pipeline fills and in_stall rises.
            if (sent >= squeeze_at && !squeeze_active) begin
                squeeze_active = 1'b1;
                repeat (SQUEEZE_LEN) send_byte(BYTE_W'($urandom), 1'b0, '0, 0);
                sent += SQUEEZE_LEN;
            end
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                // key code
                send_byte(BYTE_W'($urandom_range(0, HEADER_MIN - 1)), 1'b0, '0,
                          burst ? 0 : $urandom_range(0, MAX_GAP));
                sent++;
            end
            else if (pick < 9) begin
                // full mouse packet: header then X and Y deltas
                send_byte(BYTE_W'($urandom_range(HEADER_MIN, 255)), 1'b0, '0,
                          burst ? 0 : $urandom_range(0, MAX_GAP));
                repeat (2)
                    send_byte(BYTE_W'($urandom), 1'b0, '0,
                              burst ? 0 : $urandom_range(0, MAX_GAP));
                sent += 3;
            end
            else begin
                // any byte, whatever phase the decoder is in
                send_byte(BYTE_W'($urandom), 1'b0, '0,
                          burst ? 0 : $urandom_range(0, MAX_GAP));
                sent++;
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained();
        // let any stray result surface before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && decoded_queue.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
